[hw/rtl/shash_pkg.sv]
// shash_pkg: types, round constants, initial hash words and sigma functions
// for the SHA-256 stream hasher. No dependencies.
package shash_pkg;

    typedef logic [31:0]     word_t;
    typedef logic [7:0]      byte_t;
    typedef word_t [7:0]     work_t;     // element 0 is a / H0
    typedef logic [511:0]    window_t;   // 16-word block / schedule window
    typedef logic [5:0]      round_t;
    typedef logic [60:0]     byte_cnt_t;

    localparam byte_t  PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] LAST_BYTE  = 6'd63;
    localparam round_t LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd7;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic work_t init_hash();
        work_t h;
        h[0] = 32'h6a09e667;
        h[1] = 32'hbb67ae85;
        h[2] = 32'h3c6ef372;
        h[3] = 32'ha54ff53a;
        h[4] = 32'h510e527f;
        h[5] = 32'h9b05688c;
        h[6] = 32'h1f83d9ab;
        h[7] = 32'h5be0cd19;
        return h;
    endfunction

    function automatic word_t round_k(input round_t i);
        word_t k;
        case (i)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

[hw/rtl/shash_round.sv]
// shash_round: one SHA-256 compression round plus the next schedule word.
// Depends on shash_pkg.
module shash_round (
    input  shash_pkg::work_t   v_in,
    input  shash_pkg::round_t  round_idx,
    input  shash_pkg::window_t win,
    output shash_pkg::work_t   v_out,
    output shash_pkg::word_t   w_new
);

    shash_pkg::word_t w0, w1, w9, w14, t1, t2, ch, maj;

    // window holds W[t] in the top word, W[t+15] in the bottom word
    assign w0  = win[511:480];
    assign w1  = win[479:448];
    assign w9  = win[223:192];
    assign w14 = win[63:32];

    assign w_new = shash_pkg::small_sigma1(w14) + w9 + shash_pkg::small_sigma0(w1) + w0;

    assign ch  = (v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]);
    assign maj = (v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]);
    assign t1  = v_in[7] + shash_pkg::big_sigma1(v_in[4]) + ch
               + shash_pkg::round_k(round_idx) + w0;
    assign t2  = shash_pkg::big_sigma0(v_in[0]) + maj;

    assign v_out[0] = t1 + t2;
    assign v_out[1] = v_in[0];
    assign v_out[2] = v_in[1];
    assign v_out[3] = v_in[2];
    assign v_out[4] = v_in[3] + t1;
    assign v_out[5] = v_in[4];
    assign v_out[6] = v_in[5];
    assign v_out[7] = v_in[6];

endmodule

[hw/rtl/sha256_stream_hash_top.sv]
// sha256_stream_hash_top: SHA-256 over a byte stream, digest out as 8 words.
// Depends on shash_pkg and shash_round.
//
//  channel | ports                                        | role
//  s_      | s_func, s_data_byte                          | absorb byte / finish
//  m_      | m_digest_word, m_word_index, m_last_word     | digest, 8 beats
//
// Absorb beat: the 64th byte of a block starts the compression rounds, then the fold.
// Finish beat: one pad byte per cycle up to the block end, then the block is compressed;
// with fewer than 9 bytes free a second block is padded and compressed as well.
// Then 8 output beats. One shared round unit serves every round.
// s_ready is low while compressing, padding or emitting; m_ valid holds under stall.
// Synchronous active-low reset loads the initial hash words and empties the buffer.
module sha256_stream_hash_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_func,
    input  logic [7:0]          s_data_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [31:0]         m_digest_word,
    output logic [2:0]          m_word_index,
    output logic                m_last_word
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } state_t;

    state_t                 state_reg;
    shash_pkg::work_t       h_reg;
    shash_pkg::work_t       v_reg;
    shash_pkg::window_t     blk_reg;
    shash_pkg::round_t      rnd_reg;
    logic [5:0]             fill_reg;
    shash_pkg::byte_cnt_t   byte_cnt_reg;
    logic [63:0]            len_reg;
    logic                   pad_reg;
    logic                   first_reg;
    logic                   extra_reg;
    logic                   m_valid_reg;
    shash_pkg::word_t       m_word_reg;
    logic [2:0]             m_idx_reg;

    shash_pkg::work_t       v_step;
    shash_pkg::word_t       w_new;
    shash_pkg::byte_t       pad_byte;
    logic [2:0]             idx_inc;

    shash_round u_round (
        .v_in      (v_reg),
        .round_idx (rnd_reg),
        .win       (blk_reg),
        .v_out     (v_step),
        .w_new     (w_new)
    );

    // length bytes go in the last 8 slots of the final block
    always_comb begin
        if (first_reg) begin
            pad_byte = shash_pkg::PAD_MARK;
        end else if (fill_reg >= shash_pkg::LEN_POS && !extra_reg) begin
            pad_byte = len_reg[63:56];
        end else begin
            pad_byte = 8'h00;
        end
    end

    assign idx_inc = m_idx_reg + 3'd1;

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_digest_word = m_word_reg;
    assign m_word_index  = m_idx_reg;
    assign m_last_word   = (m_idx_reg == shash_pkg::LAST_WORD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            h_reg        <= shash_pkg::init_hash();
            rnd_reg      <= '0;
            fill_reg     <= '0;
            byte_cnt_reg <= '0;
            pad_reg      <= 1'b0;
            first_reg    <= 1'b0;
            extra_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
            m_idx_reg    <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (!s_func) begin
                            blk_reg      <= {blk_reg[503:0], s_data_byte};
                            fill_reg     <= fill_reg + 6'd1;
                            byte_cnt_reg <= byte_cnt_reg + 61'd1;
                            if (fill_reg == shash_pkg::LAST_BYTE) begin
                                v_reg     <= h_reg;
                                rnd_reg   <= '0;
                                state_reg <= ST_ROUND;
                            end
                        end else begin
                            pad_reg   <= 1'b1;
                            first_reg <= 1'b1;
                            len_reg   <= {byte_cnt_reg, 3'b000};
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    blk_reg   <= {blk_reg[503:0], pad_byte};
                    fill_reg  <= fill_reg + 6'd1;
                    first_reg <= 1'b0;
                    if (first_reg && fill_reg >= shash_pkg::LEN_POS) begin
                        extra_reg <= 1'b1;
                    end
                    if (!first_reg && fill_reg >= shash_pkg::LEN_POS && !extra_reg) begin
                        len_reg <= {len_reg[55:0], 8'h00};
                    end
                    if (fill_reg == shash_pkg::LAST_BYTE) begin
                        v_reg     <= h_reg;
                        rnd_reg   <= '0;
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    v_reg   <= v_step;
                    blk_reg <= {blk_reg[479:0], w_new};
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == shash_pkg::LAST_ROUND) begin
                        state_reg <= ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    for (int i = 0; i < 8; i++) begin
                        h_reg[3'(i)] <= h_reg[3'(i)] + v_reg[3'(i)];
                    end
                    if (!pad_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (extra_reg) begin
                        extra_reg <= 1'b0;
                        state_reg <= ST_PAD;
                    end else begin
                        m_valid_reg <= 1'b1;
                        m_idx_reg   <= '0;
                        m_word_reg  <= h_reg[0] + v_reg[0];
                        state_reg   <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        if (m_idx_reg == shash_pkg::LAST_WORD) begin
                            m_valid_reg  <= 1'b0;
                            m_idx_reg    <= '0;
                            h_reg        <= shash_pkg::init_hash();
                            fill_reg     <= '0;
                            byte_cnt_reg <= '0;
                            pad_reg      <= 1'b0;
                            state_reg    <= ST_IDLE;
                        end else begin
                            m_idx_reg  <= idx_inc;
                            m_word_reg <= h_reg[idx_inc];
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
